/* hw/rtl/fgps_pkg.sv */
// Shared widths, register codes, reset values and payload types of the pixel grain stage.
`timescale 1ns / 1ps
`default_nettype none
package fgps_pkg;

  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned DUST_DRAW_W  = 30;
  localparam int unsigned GRAIN_DRAW_W = 16;
  localparam int unsigned THRESH_W     = 6;
  localparam int unsigned FLICKER_W    = 4;
  localparam int unsigned AMOUNT_W     = 9;
  localparam int unsigned DUST_LIM_W   = 10;
  localparam int unsigned CFG_DATA_W   = 10;
  localparam int unsigned CFG_INDEX_W  = 3;

  localparam int unsigned CHAN_MAX   = 255;
  localparam int unsigned GRAIN_BASE = 40;

  // Index into the grain range: base plus channel sum over 32 (at most 40 + 23).
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PROD_W = AMOUNT_W + IDX_W;
  // Largest grain range: full amount times largest index, floored Q0.8.
  localparam int unsigned RANGE_MAX =
    (((1 << AMOUNT_W) - 1) * (GRAIN_BASE + ((3 * CHAN_MAX) >> 5))) >> 8;
  localparam int unsigned RANGE_W = $clog2(RANGE_MAX + 1);

  // Draw bits resolved per modulo stage.
  localparam int unsigned MOD_STEP = 2;

  localparam logic [THRESH_W-1:0]   RST_THRESHOLD = THRESH_W'(20);
  localparam logic [FLICKER_W-1:0]  RST_FLICKER   = FLICKER_W'(0);
  localparam logic [AMOUNT_W-1:0]   RST_AMOUNT    = AMOUNT_W'(128);
  localparam logic [AMOUNT_W-1:0]   RST_GAIN_R    = AMOUNT_W'(192);
  localparam logic [AMOUNT_W-1:0]   RST_GAIN_G    = AMOUNT_W'(256);
  localparam logic [AMOUNT_W-1:0]   RST_GAIN_B    = AMOUNT_W'(128);
  localparam logic [DUST_LIM_W-1:0] RST_DUST_LIM  = DUST_LIM_W'(200);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_FLICKER   = 3'd1,
    REG_AMOUNT    = 3'd2,
    REG_GAIN_R    = 3'd3,
    REG_GAIN_G    = 3'd4,
    REG_GAIN_B    = 3'd5,
    REG_DUST_LIM  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [THRESH_W-1:0]        threshold;
    logic signed [FLICKER_W-1:0] flicker;
    logic [AMOUNT_W-1:0]        amount;
    logic [AMOUNT_W-1:0]        gain_r;
    logic [AMOUNT_W-1:0]        gain_g;
    logic [AMOUNT_W-1:0]        gain_b;
    logic [DUST_LIM_W-1:0]      dust_limit;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]      pixel;
    logic [DUST_DRAW_W-1:0]  dust_draw;
    logic                    dust_white;
    logic [GRAIN_DRAW_W-1:0] grain_draw;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0]       a;
    logic [CHAN_W-1:0]       b;
    logic [CHAN_W-1:0]       g;
    logic [CHAN_W-1:0]       r;
    logic                    dust;
    logic                    white;
    logic [GRAIN_DRAW_W-1:0] draw;
    logic [RANGE_W-1:0]      grain_range;
  } pix_t;

endpackage
`default_nettype wire

/* hw/rtl/fgps_in_if.sv */
// Input channel: pixel beat with its random draws.
`timescale 1ns / 1ps
`default_nettype none
interface fgps_in_if;
  import fgps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PIXEL_W-1:0]      pixel_in;
  logic [DUST_DRAW_W-1:0]  dust_draw;
  logic                    dust_white;
  logic [GRAIN_DRAW_W-1:0] grain_draw;

  modport source (output valid, pixel_in, dust_draw, dust_white, grain_draw, input ready);
  modport sink   (input valid, pixel_in, dust_draw, dust_white, grain_draw, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fgps_out_if.sv */
// Output channel: grained pixel beat.
`timescale 1ns / 1ps
`default_nettype none
interface fgps_out_if;
  import fgps_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fgps_front.sv */
// Front stages: dust test and range squeeze, then grain range from the channel sum.
`timescale 1ns / 1ps
`default_nettype none
module fgps_front (
  input  logic               clk,
  input  logic               rst,
  input  fgps_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  fgps_pkg::in_beat_t in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output fgps_pkg::pix_t     out_pix
);
  import fgps_pkg::*;

  logic s1_valid;
  pix_t s1_pix;
  logic s1_en;
  logic s2_en;
  pix_t s2_pix_next;

  logic [SUM_W-1:0]   sum;
  logic [IDX_W-1:0]   idx;
  logic [PROD_W-1:0]  prod;
  logic               is_dust;

  // Clamp to [t/2, 255-t], add flicker, clamp to a byte.
  function automatic logic [CHAN_W-1:0] squeeze(
    input logic [CHAN_W-1:0]           c,
    input logic [THRESH_W-1:0]         t,
    input logic signed [FLICKER_W-1:0] f
  );
    logic [CHAN_W-1:0]       lo;
    logic [CHAN_W-1:0]       hi;
    logic [CHAN_W-1:0]       v;
    logic signed [CHAN_W+1:0] s;
    lo = CHAN_W'(t >> 1);
    hi = CHAN_W'(CHAN_MAX) - CHAN_W'(t);
    if (c < lo) begin
      v = lo;
    end else if (c > hi) begin
      v = hi;
    end else begin
      v = c;
    end
    s = $signed({2'b00, v}) + $signed({{(CHAN_W + 2 - FLICKER_W){f[FLICKER_W-1]}}, f});
    if (s < 0) begin
      return '0;
    end else if (s > $signed((CHAN_W + 2)'(CHAN_MAX))) begin
      return CHAN_W'(CHAN_MAX);
    end else begin
      return s[CHAN_W-1:0];
    end
  endfunction

  assign s2_en    = !out_valid || out_ready;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  assign is_dust = in_beat.dust_draw < DUST_DRAW_W'(cfg.dust_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
    if (s1_en) begin
      s1_pix.a           <= in_beat.pixel[3*CHAN_W +: CHAN_W];
      s1_pix.b           <= squeeze(in_beat.pixel[2*CHAN_W +: CHAN_W], cfg.threshold, cfg.flicker);
      s1_pix.g           <= squeeze(in_beat.pixel[CHAN_W +: CHAN_W], cfg.threshold, cfg.flicker);
      s1_pix.r           <= squeeze(in_beat.pixel[0 +: CHAN_W], cfg.threshold, cfg.flicker);
      s1_pix.dust        <= is_dust;
      s1_pix.white       <= in_beat.dust_white;
      s1_pix.draw        <= in_beat.grain_draw;
      s1_pix.grain_range <= '0;
    end
  end

  assign sum  = SUM_W'(s1_pix.r) + SUM_W'(s1_pix.g) + SUM_W'(s1_pix.b);
  assign idx  = IDX_W'(GRAIN_BASE) + IDX_W'(sum >> 5);
  assign prod = PROD_W'(cfg.amount) * PROD_W'(idx);

  // Carry the beat forward with the floored Q0.8 grain range filled in.
  always_comb begin
    s2_pix_next             = s1_pix;
    s2_pix_next.grain_range = prod[8 +: RANGE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_en) begin
      out_valid <= s1_valid;
    end
    if (s2_en) begin
      out_pix <= s2_pix_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fgps_mod.sv */
// Pipelined remainder of the grain draw by the grain range, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module fgps_mod #(
  parameter int unsigned ModStep = fgps_pkg::MOD_STEP
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fgps_pkg::pix_t              in_pix,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fgps_pkg::pix_t              out_pix,
  output logic [fgps_pkg::RANGE_W-1:0] out_rem
);
  import fgps_pkg::*;

  localparam int unsigned Stages = GRAIN_DRAW_W / ModStep;

  logic [Stages-1:0] valid;
  logic [Stages-1:0] en;
  pix_t              pay [Stages];
  logic [RANGE_W-1:0] rem [Stages];

  // One restoring step: shift in a draw bit, subtract the divisor if it fits.
  function automatic logic [RANGE_W-1:0] mod_step(
    input logic [RANGE_W-1:0] r,
    input logic               b,
    input logic [RANGE_W-1:0] d
  );
    logic [RANGE_W:0] sh;
    sh = {r, b};
    if (sh >= {1'b0, d}) begin
      sh = sh - {1'b0, d};
    end
    return sh[RANGE_W-1:0];
  endfunction

  always_comb begin
    en[Stages-1] = !valid[Stages-1] || out_ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[Stages-1];
  assign out_pix   = pay[Stages-1];
  assign out_rem   = rem[Stages-1];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic               v_src;
    pix_t               pay_src;
    logic [RANGE_W-1:0] rem_src;
    logic [RANGE_W-1:0] rem_new;

    if (s == 0) begin : g_head
      assign v_src   = in_valid;
      assign pay_src = in_pix;
      assign rem_src = '0;
    end else begin : g_body
      assign v_src   = valid[s-1];
      assign pay_src = pay[s-1];
      assign rem_src = rem[s-1];
    end

    always_comb begin
      rem_new = rem_src;
      for (int k = 0; k < ModStep; k++) begin
        rem_new = mod_step(rem_new, pay_src.draw[GRAIN_DRAW_W-1-s*ModStep-k],
                           pay_src.grain_range);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en[s]) begin
        valid[s] <= v_src;
      end
      if (en[s]) begin
        pay[s] <= pay_src;
        rem[s] <= rem_new;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fgps_darken.sv */
// Last stage: apply grain per channel or dust color, and hold the output beat.
`timescale 1ns / 1ps
`default_nettype none
module fgps_darken (
  input  logic                        clk,
  input  logic                        rst,
  input  fgps_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fgps_pkg::pix_t              in_pix,
  input  logic [fgps_pkg::RANGE_W-1:0] in_rem,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fgps_pkg::PIXEL_W-1:0] out_pixel
);
  import fgps_pkg::*;

  logic               en;
  logic [RANGE_W-1:0] grain;
  logic [CHAN_W-1:0]  r_new;
  logic [CHAN_W-1:0]  g_new;
  logic [CHAN_W-1:0]  b_new;

  // floor((c*256 - grain*gain) / 256), floored at zero.
  function automatic logic [CHAN_W-1:0] darken(
    input logic [CHAN_W-1:0]   c,
    input logic [RANGE_W-1:0]  gr,
    input logic [AMOUNT_W-1:0] gain
  );
    logic [2*CHAN_W-1:0]      p;
    logic signed [2*CHAN_W+1:0] v;
    p = (2*CHAN_W)'(gr) * (2*CHAN_W)'(gain);
    v = $signed({2'b00, c, 8'h00}) - $signed({2'b00, p});
    if (v <= 0) begin
      return '0;
    end else begin
      return v[8 +: CHAN_W];
    end
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign grain    = (in_pix.grain_range == '0) ? '0 : in_rem;

  always_comb begin
    if (in_pix.dust) begin
      r_new = in_pix.white ? CHAN_W'(CHAN_MAX) : '0;
      g_new = r_new;
      b_new = r_new;
    end else begin
      r_new = darken(in_pix.r, grain, cfg.gain_r);
      g_new = darken(in_pix.g, grain, cfg.gain_g);
      b_new = darken(in_pix.b, grain, cfg.gain_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_pixel <= {in_pix.a, b_new, g_new, r_new};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/film_grain_pixel_stage.sv */
// Top level of the per-pixel grain stage: configuration registers and the pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel grain stage for an RGBA8888 stream. Each beat on upstream carries one pixel
// (red 7:0, green 15:8, blue 23:16, alpha 31:24) plus its random draws; each beat on
// downstream carries the grained pixel, alpha copied. Dust pixels go to solid black or
// white; other pixels are squeezed into the per-frame range, shifted by flicker, then
// darkened by a grain value scaled per channel. Throughput is one pixel per clock while
// downstream is ready. The pipe is two front stages, the remainder pipeline that
// resolves ModStep draw bits per stage, and the output register. The remainder pipeline
// sets the latency. Every stage holds its beat on a stall and takes a new one whenever it
// is empty or moving, so bubbles collapse and upstream keeps flowing while the output beat
// waits. Write the registers only while the pipe is empty; the channel math reads them
// live in the front and darken stages.
module film_grain_pixel_stage #(
  parameter int unsigned ModStep = fgps_pkg::MOD_STEP
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fgps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fgps_pkg::CFG_DATA_W-1:0]  cfg_data,
  fgps_in_if.sink                         upstream,
  fgps_out_if.source                      downstream
);
  import fgps_pkg::*;

  cfg_t     cfg;
  in_beat_t in_beat;

  // Front to remainder pipeline.
  logic front_valid;
  logic front_ready;
  pix_t front_pix;

  // Remainder pipeline to the darken stage.
  logic               mod_valid;
  logic               mod_ready;
  pix_t               mod_pix;
  logic [RANGE_W-1:0] mod_rem;

  // Register file: hold values, ignore writes beyond the last register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= RST_THRESHOLD;
      cfg.flicker    <= RST_FLICKER;
      cfg.amount     <= RST_AMOUNT;
      cfg.gain_r     <= RST_GAIN_R;
      cfg.gain_g     <= RST_GAIN_G;
      cfg.gain_b     <= RST_GAIN_B;
      cfg.dust_limit <= RST_DUST_LIM;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold  <= cfg_data[THRESH_W-1:0];
        REG_FLICKER:   cfg.flicker    <= cfg_data[FLICKER_W-1:0];
        REG_AMOUNT:    cfg.amount     <= cfg_data[AMOUNT_W-1:0];
        REG_GAIN_R:    cfg.gain_r     <= cfg_data[AMOUNT_W-1:0];
        REG_GAIN_G:    cfg.gain_g     <= cfg_data[AMOUNT_W-1:0];
        REG_GAIN_B:    cfg.gain_b     <= cfg_data[AMOUNT_W-1:0];
        REG_DUST_LIM:  cfg.dust_limit <= cfg_data[DUST_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_beat.pixel      = upstream.pixel_in;
  assign in_beat.dust_draw  = upstream.dust_draw;
  assign in_beat.dust_white = upstream.dust_white;
  assign in_beat.grain_draw = upstream.grain_draw;

  // Dust test and squeeze, then the grain range (one 9x6 multiply).
  fgps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (upstream.valid),
    .in_ready  (upstream.ready),
    .in_beat   (in_beat),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_pix   (front_pix)
  );

  // Remainder of the draw by the range, ModStep bits per stage.
  fgps_mod #(
    .ModStep (ModStep)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_pix    (front_pix),
    .out_valid (mod_valid),
    .out_ready (mod_ready),
    .out_pix   (mod_pix),
    .out_rem   (mod_rem)
  );

  // Grain times gain per channel, or dust color; drives the output register.
  fgps_darken u_darken (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mod_valid),
    .in_ready  (mod_ready),
    .in_pix    (mod_pix),
    .in_rem    (mod_rem),
    .out_valid (downstream.valid),
    .out_ready (downstream.ready),
    .out_pixel (downstream.pixel_out)
  );

`ifndef ASSERT_OFF
  // The pipe comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !downstream.valid)
    else $error("output beat valid right after reset");

  // The grain range never exceeds what the widest amount and channel sum allow.
  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> front_pix.grain_range <= RANGE_W'(RANGE_MAX))
    else $error("grain range out of bound");

  // A finished remainder is below its divisor.
  a_rem_below_range: assert property (@(posedge clk) disable iff (rst)
    mod_valid && (mod_pix.grain_range != '0) |-> mod_rem < mod_pix.grain_range)
    else $error("grain remainder not below grain range");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the per-pixel grain stage: directed rows, random phases.
`timescale 1ns / 1ps
module tb_top;
  import fgps_pkg::*;

  // Unused register index: writes there must leave every setting alone.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam int CH_TOP          = CHAN_MAX;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int BURST_ITEMS     = 40;
  // Margin after the final drain, to catch stray beats at the end.
  localparam int DRAIN_CYCLES    = 30;

  // One directed row: the input beat, and a hand-typed output where it is obvious.
  typedef struct packed {
    logic [PIXEL_W-1:0]      pixel;
    logic [DUST_DRAW_W-1:0]  dust;
    logic                    white;
    logic [GRAIN_DRAW_W-1:0] draw;
    logic                    typed;
    logic [PIXEL_W-1:0]      px;
  } dir_row_t;

  localparam int DIR_ROWS = 12;
  // All rows run with the reset settings: threshold 20, no flicker, amount 128,
  // gains 192/256/128, dust limit 200.
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // dust, black: alpha survives, colors go to zero
    '{32'h12345678, 30'd0,          1'b0, 16'h0000, 1'b1, 32'h12000000},
    // dust, white, draw just under the limit
    '{32'hAB000000, 30'd199,        1'b1, 16'h0000, 1'b1, 32'hABFFFFFF},
    // draw equal to the limit is not dust: black lifts to t/2 = 10, grain 0
    '{32'h00000000, 30'd200,        1'b0, 16'h0000, 1'b1, 32'h000A0A0A},
    // full white drops to 255 - t = 235, grain 0
    '{32'hFFFFFFFF, 30'd1000,       1'b0, 16'h0000, 1'b1, 32'hFFEBEBEB},
    '{32'hFF000000, 30'h3FFFFFFF,   1'b1, 16'hFFFF, 1'b0, 32'h0},
    '{32'h00FFFFFF, 30'd199,        1'b0, 16'hFFFF, 1'b1, 32'h00000000},
    '{32'h80808080, 30'd500,        1'b0, 16'd19,   1'b0, 32'h0},
    '{32'h00FF00FF, 30'd1000,       1'b1, 16'hFFFF, 1'b0, 32'h0},
    '{32'h7F0000FF, 30'd0,          1'b1, 16'h1234, 1'b1, 32'h7FFFFFFF},
    '{32'h01020304, 30'd999999999,  1'b0, 16'h8000, 1'b0, 32'h0},
    '{32'hC0FF8000, 30'd12345,      1'b0, 16'd12345,1'b0, 32'h0},
    '{32'h55AAAA55, 30'd200,        1'b1, 16'h5555, 1'b0, 32'h0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fgps_in_if  up_ch ();
  fgps_out_if down_ch ();

  film_grain_pixel_stage dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .upstream   (up_ch),
    .downstream (down_ch)
  );

  always #10 clk = ~clk;

  // Register image as the block should hold it; updated on every write burst.
  cfg_t grain_cfg;
  // Grained pixels still owed by the block, oldest first.
  logic [PIXEL_W-1:0] grained_q [$];
  int  mismatches = 0;
  bit  hold_off_req = 1'b0;
  bit  feed_steady = 1'b0;
  bit  drain_steady = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp into [t/2, 255-t], add flicker, clamp into 0..255.
  function automatic logic [CHAN_W-1:0] squeeze_chan(input cfg_t c, input logic [CHAN_W-1:0] v);
    int lo, hi, x;
    lo = int'(c.threshold) >> 1;
    hi = CH_TOP - int'(c.threshold);
    x  = int'(v);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    x = x + int'($signed(c.flicker));
    if (x < 0) x = 0;
    else if (x > CH_TOP) x = CH_TOP;
    return CHAN_W'(x);
  endfunction

  function automatic logic [PIXEL_W-1:0] grain_pixel(input cfg_t c, input in_beat_t b);
    logic [CHAN_W-1:0] ch [3];
    int unsigned gain [3];
    int unsigned sum, span, grain;
    int lvl;
    gain[0] = c.gain_r;
    gain[1] = c.gain_g;
    gain[2] = c.gain_b;
    for (int i = 0; i < 3; i++) ch[i] = b.pixel[CHAN_W*i +: CHAN_W];
    if (b.dust_draw < c.dust_limit) begin
      // Dust wipes all three colors; no grain, no flicker.
      for (int i = 0; i < 3; i++) ch[i] = {CHAN_W{b.dust_white}};
    end else begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        ch[i] = squeeze_chan(c, ch[i]);
        sum += ch[i];
      end
      // Grain range is the floored Q0.8 product of amount and index.
      span  = (int'(c.amount) * (GRAIN_BASE + (sum >> 5))) >> 8;
      grain = (span == 0) ? 0 : int'(b.grain_draw) % span;
      for (int i = 0; i < 3; i++) begin
        lvl = int'(ch[i]) * 256 - int'(grain * gain[i]);
        if (lvl <= 0) ch[i] = '0;
        else if ((lvl >> 8) > CH_TOP) ch[i] = CHAN_W'(CH_TOP);
        else ch[i] = CHAN_W'(lvl >> 8);
      end
    end
    return {b.pixel[PIXEL_W-1 -: CHAN_W], ch[2], ch[1], ch[0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often short, rarely long.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic in_beat_t draw_pixel_beat();
    in_beat_t b;
    int unsigned r;
    b.pixel = $urandom;
    // Push single channels to the rails now and then.
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) b.pixel[CHAN_W*i +: CHAN_W] = '0;
      else if (r < 16) b.pixel[CHAN_W*i +: CHAN_W] = '1;
    end
    // Keep dust draws near the limits often enough to hit both sides.
    r = $urandom_range(0, 99);
    if (r < 30) b.dust_draw = DUST_DRAW_W'($urandom_range(0, 1100));
    else if (r < 35) b.dust_draw = '1 - DUST_DRAW_W'($urandom_range(0, 1000));
    else b.dust_draw = DUST_DRAW_W'($urandom);
    b.dust_white = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) b.grain_draw = '0;
    else if (r < 10) b.grain_draw = '1;
    else b.grain_draw = GRAIN_DRAW_W'($urandom);
    return b;
  endfunction

  // Settings for each phase: reset, all minimum, all maximum, the nominal
  // extremes, then random frames with the odd out-of-range value.
  function automatic cfg_t phase_settings(input int p);
    cfg_t c;
    case (p)
      1: begin
        c.threshold = '0;
        c.flicker = 4'b1000;    // most negative offset
        c.amount = '0;          // zero range: no grain at all
        c.gain_r = '0;
        c.gain_g = '0;
        c.gain_b = '0;
        c.dust_limit = '0;      // no dust possible
      end
      2: begin
        c.threshold = '1;
        c.flicker = 4'sd7;
        c.amount = '1;
        c.gain_r = '1;
        c.gain_g = '1;
        c.gain_b = '1;
        c.dust_limit = '1;
      end
      3: begin
        c.threshold = 6'd44;
        c.flicker = -4'sd7;
        c.amount = 9'd256;
        c.gain_r = 9'd256;
        c.gain_g = 9'd256;
        c.gain_b = 9'd256;
        c.dust_limit = 10'd1000;
      end
      default: begin
        c.threshold = ($urandom_range(0, 4) == 0) ? THRESH_W'($urandom) : THRESH_W'($urandom_range(0, 44));
        c.flicker = FLICKER_W'($urandom);
        c.amount = ($urandom_range(0, 3) == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 256));
        c.gain_r = ($urandom_range(0, 3) == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 256));
        c.gain_g = ($urandom_range(0, 3) == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 256));
        c.gain_b = ($urandom_range(0, 3) == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 256));
        c.dust_limit = ($urandom_range(0, 3) == 0) ? DUST_LIM_W'($urandom) : DUST_LIM_W'($urandom_range(0, 1000));
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write every register, then the spare index. With noise set, fill the bits
  // above each register's width with junk; the block must drop them.
  task automatic write_settings(input cfg_t c, input bit noise);
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i <= REG_SPARE; i++) begin
      data = noise ? CFG_DATA_W'($urandom) : '0;
      case (CFG_INDEX_W'(i))
        REG_THRESHOLD: data[THRESH_W-1:0]   = c.threshold;
        REG_FLICKER:   data[FLICKER_W-1:0]  = c.flicker;
        REG_AMOUNT:    data[AMOUNT_W-1:0]   = c.amount;
        REG_GAIN_R:    data[AMOUNT_W-1:0]   = c.gain_r;
        REG_GAIN_G:    data[AMOUNT_W-1:0]   = c.gain_g;
        REG_GAIN_B:    data[AMOUNT_W-1:0]   = c.gain_b;
        REG_DUST_LIM:  data[DUST_LIM_W-1:0] = c.dust_limit;
        default:       data = CFG_DATA_W'($urandom);
      endcase
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= data;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    grain_cfg = c;
  endtask

  // Offer one beat and hold it until taken; leave valid high for a
  // back-to-back follow-up.
  task automatic send_pixel(input in_beat_t b, input logic [PIXEL_W-1:0] want);
    up_ch.valid      <= 1'b1;
    up_ch.pixel_in   <= b.pixel;
    up_ch.dust_draw  <= b.dust_draw;
    up_ch.dust_white <= b.dust_white;
    up_ch.grain_draw <= b.grain_draw;
    do @(posedge clk); while (!up_ch.ready);
    grained_q.push_back(want);
  endtask

  task automatic idle_feed(input int unsigned gap);
    if (gap != 0) begin
      up_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every owed pixel to come out.
  task automatic drain_pipe();
    up_ch.valid <= 1'b0;
    while (grained_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    down_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // Hold ready low long enough for the pipe to fill and back up.
        down_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        down_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        down_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        down_ch.ready <= 1'b1;
        stall_left = pick_gap(drain_steady);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output beat against the oldest owed pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [PIXEL_W-1:0] want;
    if (!rst && down_ch.valid && down_ch.ready) begin
      if (grained_q.size() == 0) begin
        $display("%0t: pixel_out %h arrived, expected none", $time, down_ch.pixel_out);
        mismatches++;
      end else begin
        want = grained_q.pop_front();
        if (down_ch.pixel_out !== want) begin
          $display("%0t: pixel_out expected %h actual %h", $time, want, down_ch.pixel_out);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_beat_t    b;
    int unsigned burst_left;
    burst_left = 0;
    grain_cfg = '{threshold: RST_THRESHOLD, flicker: RST_FLICKER, amount: RST_AMOUNT,
                  gain_r: RST_GAIN_R, gain_g: RST_GAIN_G, gain_b: RST_GAIN_B,
                  dust_limit: RST_DUST_LIM};
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    up_ch.valid      <= 1'b0;
    up_ch.pixel_in   <= '0;
    up_ch.dust_draw  <= '0;
    up_ch.dust_white <= 1'b0;
    up_ch.grain_draw <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset settings; typed results where obvious.
    foreach (DIRECTED_ROWS[i]) begin
      b.pixel      = DIRECTED_ROWS[i].pixel;
      b.dust_draw  = DIRECTED_ROWS[i].dust;
      b.dust_white = DIRECTED_ROWS[i].white;
      b.grain_draw = DIRECTED_ROWS[i].draw;
      send_pixel(b, DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].px : grain_pixel(grain_cfg, b));
      idle_feed(pick_gap(1'b0));
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        // Settings change only with the pipe empty.
        drain_pipe();
        write_settings(phase_settings(p), p >= 4);
      end
      feed_steady  = ($urandom_range(0, 3) == 0);
      drain_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 2 && k == 60) begin
          // Long receiver hold-off while the sender keeps pushing.
          hold_off_req = 1'b1;
          burst_left = BURST_ITEMS;
        end
        if (p == 3 && k == 100) drain_pipe();   // sender pause until all pixels are back
        b = draw_pixel_beat();
        send_pixel(b, grain_pixel(grain_cfg, b));
        if (burst_left != 0) burst_left--;
        else idle_feed(pick_gap(feed_steady));
      end
    end

    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
